FILE: rtl/fixed_log2_log10_estimator_core_assert.svh
// Assertion macros shared by the log estimator checker.
// No dependencies; take in with `include before use.
`ifndef FIXED_LOG2_LOG10_ESTIMATOR_CORE_ASSERT_SVH
`define FIXED_LOG2_LOG10_ESTIMATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while rst is high
`define FL2E_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while rst is high
`define FL2E_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/fl2e_pkg.sv
// Package for the fixed-point log2/log10 estimator: widths and mantissa table.
// No dependencies.
package fl2e_pkg;

   // Field widths
   localparam int VALUE_W  = 32;
   localparam int FRAC_W   = 16;
   localparam int EXP_W    = 6;
   localparam int LOG2_W   = 1 + EXP_W + FRAC_W;
   localparam int LOG10_W  = 21;
   localparam int POS_W    = $clog2(VALUE_W);
   localparam int WIN_W    = 5;
   localparam int MANT_W   = 17;
   localparam int TABLE_SIZE = 17;
   localparam int IDX_W    = $clog2(TABLE_SIZE);

   // log10 scaling: log10(2) ~ 1233 / 4096, applied as (x >> 1) * 1233 >> 11
   localparam int SCALE_W     = 11;
   localparam int PROD_W      = (LOG2_W - 2) + SCALE_W;
   localparam int LOG10_SHIFT = 11;
   localparam logic [SCALE_W-1:0] LOG10_SCALE = SCALE_W'(1233);

   // Result for a zero operand
   localparam logic signed [LOG2_W-1:0] ZERO_LOG = LOG2_W'(-65536);

   typedef logic signed [MANT_W-1:0] mant_type;

   // round(2^16 * log2(1/2 + i/32)) for i = 0..16
   localparam mant_type MANT_TABLE [TABLE_SIZE] = '{
      mant_type'(-65536), mant_type'(-59804), mant_type'(-54400), mant_type'(-49288),
      mant_type'(-44438), mant_type'(-39825), mant_type'(-35427), mant_type'(-31224),
      mant_type'(-27200), mant_type'(-23340), mant_type'(-19632), mant_type'(-16064),
      mant_type'(-12625), mant_type'(-9307),  mant_type'(-6102),  mant_type'(-3002),
      mant_type'(0)
   };

endpackage

FILE: rtl/fixed_log2_log10_estimator_core.sv
// Fixed-point log2/log10 estimator, Q7.16/Q5.16, valid/ready on both sides.
// Depends on fl2e_pkg.
//
// Takes one 32-bit unsigned value per transfer and returns 2^16*log2 and
// 2^16*log10 estimates from a leading-one search and a 17-entry mantissa
// table (four bits after the leading one, rounded by the fifth). Zero gives
// -65536 on both results. One item is accepted every clock cycle while
// req_ready is high. The value is captured in the input register at its
// transfer, and the single-pass datapath then fills the result register
// from it, which raises rsp_valid; the result leaves when rsp_ready is high.
// A stalled result holds the result register and then the input register,
// so two items fill the block before req_ready drops.
// The block holds no state beyond the two pipeline registers.
module fixed_log2_log10_estimator_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [fl2e_pkg::VALUE_W-1:0]           req_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [fl2e_pkg::LOG2_W-1:0]     rsp_log2_estimate,
   output logic signed [fl2e_pkg::LOG10_W-1:0]    rsp_log10_estimate
);
   import fl2e_pkg::*;

   logic                       in_valid_ff, in_valid_in;
   logic [VALUE_W-1:0]         in_value_ff;
   logic                       out_valid_ff, out_valid_in;
   logic signed [LOG2_W-1:0]   out_log2_ff;
   logic signed [LOG10_W-1:0]  out_log10_ff;

   logic                       out_free;
   logic                       in_free;
   logic [POS_W-1:0]           lead_pos;
   logic [VALUE_W+WIN_W-1:0]   ext_value;
   logic [WIN_W-1:0]           window;
   logic [IDX_W-1:0]           tbl_idx;
   logic [EXP_W-1:0]           exponent;
   mant_type                   mant;
   logic signed [LOG2_W-1:0]   log2_in;
   logic [LOG2_W-3:0]          half_log2;
   logic [PROD_W-1:0]          prod;
   logic signed [LOG10_W-1:0]  log10_in;

   // Stage handshake: advance when the next stage has room
   assign out_free     = !out_valid_ff || rsp_ready;
   assign in_free      = !in_valid_ff || out_free;
   assign req_ready    = in_free;
   assign in_valid_in  = in_free ? req_valid : in_valid_ff;
   assign out_valid_in = out_free ? in_valid_ff : out_valid_ff;

   // Find the leading one (highest set bit wins)
   always_comb begin
      lead_pos = '0;
      for (int i = 0; i < VALUE_W; i++) begin
         if (in_value_ff[i]) begin
            lead_pos = POS_W'(i);
         end
      end
   end

   // Take the five bits below the leading one and round to a table index
   assign ext_value = {in_value_ff, {WIN_W{1'b0}}};
   assign window    = ext_value[lead_pos +: WIN_W];
   assign tbl_idx   = IDX_W'({1'b0, window[WIN_W-1:1]}) + IDX_W'(window[0]);
   assign mant      = MANT_TABLE[tbl_idx];

   // Integer part plus mantissa correction; zero has no leading one
   assign exponent = EXP_W'(lead_pos) + EXP_W'(1);
   always_comb begin
      if (in_value_ff == '0) begin
         log2_in = ZERO_LOG;
      end else begin
         log2_in = $signed({1'b0, exponent, {FRAC_W{1'b0}}}) + LOG2_W'(mant);
      end
   end

   // log10 by constant scaling for positive log2, pass through otherwise
   assign half_log2 = log2_in[LOG2_W-2:1];
   assign prod      = PROD_W'(half_log2) * PROD_W'(LOG10_SCALE);
   always_comb begin
      if (!log2_in[LOG2_W-1] && (log2_in != '0)) begin
         log10_in = $signed(prod[PROD_W-1:LOG10_SHIFT]);
      end else begin
         log10_in = $signed(log2_in[LOG10_W-1:0]);
      end
   end

   // Valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload: load input on transfer, load result when the output stage advances
   always_ff @(posedge clock) begin
      if (req_valid && in_free) begin
         in_value_ff <= req_value;
      end
      if (in_valid_ff && out_free) begin
         out_log2_ff  <= log2_in;
         out_log10_ff <= log10_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_log2_estimate  = out_log2_ff;
   assign rsp_log10_estimate = out_log10_ff;

endmodule

FILE: rtl/fl2e_checker.sv
// Port-level checker for fixed_log2_log10_estimator_core, bound to the top level.
// Depends on fl2e_pkg and fixed_log2_log10_estimator_core_assert.svh.
`include "fixed_log2_log10_estimator_core_assert.svh"

module fl2e_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic [fl2e_pkg::VALUE_W-1:0]        req_value,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [fl2e_pkg::LOG2_W-1:0]  rsp_log2_estimate,
   input logic signed [fl2e_pkg::LOG10_W-1:0] rsp_log10_estimate
);
   import fl2e_pkg::*;

   localparam logic signed [LOG2_W-1:0] LOG2_MAX = LOG2_W'(2097152);

   logic unused_inputs;
   assign unused_inputs = req_valid ^ (^req_value);

   // A stalled result holds its payload
   `FL2E_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_log2_estimate) && $stable(rsp_log10_estimate), "result changed while stalled")

   // An empty output stage leaves room for a new transfer
   `FL2E_ASSERT_IMPLY(a_ready_when_empty, clock, reset, !rsp_valid, req_ready, "input stalled with empty output stage")

   // Non-positive log2 passes through to log10 unchanged
   `FL2E_ASSERT_IMPLY(a_log10_pass, clock, reset, rsp_valid && (rsp_log2_estimate <= 0), $signed(rsp_log10_estimate) == rsp_log2_estimate, "log10 differs from non-positive log2")

   // log2 stays within the reachable range
   `FL2E_ASSERT_IMPLY(a_log2_range, clock, reset, rsp_valid, (rsp_log2_estimate >= ZERO_LOG) && (rsp_log2_estimate <= LOG2_MAX), "log2 result out of range")

endmodule

bind fixed_log2_log10_estimator_core fl2e_checker u_fl2e_checker (.*);
